// ===== design/i2cm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg: shared types and constants of the i2c master transfer engine
// Phase codes of the line sequencer, request and result records, and the
// stream packing widths.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int TDATA_W_IN  = 32;
    localparam int TDATA_W_OUT = 32;
    localparam int FIELD_LEN_W = 16;

    // bits shifted per byte on the bus
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_ST_A    = 5'd1,
        PH_ST_B    = 5'd2,
        PH_ST_C    = 5'd3,
        PH_TX_SET  = 5'd4,
        PH_TX_HIGH = 5'd5,
        PH_TX_LOW  = 5'd6,
        PH_TA_REL  = 5'd7,
        PH_TA_HIGH = 5'd8,
        PH_TA_LOW  = 5'd9,
        PH_RX_REL  = 5'd10,
        PH_RX_HIGH = 5'd11,
        PH_RX_LOW  = 5'd12,
        PH_MA_SET  = 5'd13,
        PH_MA_HIGH = 5'd14,
        PH_MA_LOW  = 5'd15,
        PH_SP_A    = 5'd16,
        PH_SP_B    = 5'd17,
        PH_SP_C    = 5'd18
    } i2cm_phase_t;

    typedef struct packed {
        logic        sda_in;
        logic [7:0]  data_byte;
        logic [15:0] length;
        logic        start_req;
    } i2cm_req_t;

    typedef struct packed {
        logic        status;
        logic        done_res;
        logic        busy_res;
        logic        rx_valid;
        logic [7:0]  rx_byte;
        logic [15:0] byte_index;
        logic        sda_output_enable;
        logic        sda_drive;
        logic        scl;
    } i2cm_res_t;

endpackage

`default_nettype wire

// ===== design/i2c_master_transfer_engine_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_transfer_engine_top: i2c master transfer engine
// Each request is one bus delay tick; each result gives the line levels and
// transfer status for that tick.
// ----------------------------------------------------------------------------
// Each request passes through the input register, then one sequencer step
// into the result register, and yields exactly one result.
// A new request is taken every cycle as long as m_tready keeps the result
// register draining; a stalled result holds back at most the one request
// sitting in the input register. Every tick advances the bus by one line
// phase: START and STOP take three ticks, each sent bit three, each received
// bit two. Lengths are masked to LEN_WIDTH bits, and a length of zero is
// taken as the address byte alone.
module i2c_master_transfer_engine_top #(
    parameter int LEN_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // start_req[0], length[16:1], data_byte[24:17], sda_in[25], zero[31:26]
    input  wire logic [31:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // scl[0], sda_drive[1], sda_output_enable[2], byte_index[18:3],
    // rx_byte[26:19], rx_valid[27], busy_res[28], done_res[29], status[30],
    // zero[31]
    output logic [31:0]      m_tdata
);

    logic                req_valid;
    logic                advance;
    i2cm_pkg::i2cm_req_t req;
    i2cm_pkg::i2cm_res_t res;

    logic                out_valid_reg;
    logic [31:0]         out_data_reg;

    assign advance = req_valid && (!out_valid_reg || m_tready);

    i2cm_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .take      (advance),
        .req_valid (req_valid),
        .req       (req)
    );

    i2cm_core #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .req     (req),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {1'b0, res};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== design/i2cm_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_in_reg: input request register
// Holds one request from the slave-side stream until the sequencer takes it.
// ----------------------------------------------------------------------------
module i2cm_in_reg (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [i2cm_pkg::TDATA_W_IN-1:0]     s_tdata,
    input  wire logic                                take,
    output logic                                     req_valid,
    output i2cm_pkg::i2cm_req_t                      req
);

    logic                valid_reg;
    i2cm_pkg::i2cm_req_t req_reg;

    assign s_tready  = !valid_reg || take;
    assign req_valid = valid_reg;
    assign req       = req_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_reg.start_req <= s_tdata[0];
            req_reg.length    <= s_tdata[16:1];
            req_reg.data_byte <= s_tdata[24:17];
            req_reg.sda_in    <= s_tdata[25];
        end
    end

endmodule

`default_nettype wire

// ===== design/i2cm_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_core: line phase sequencer
// Advances the transaction one line phase per request and forms the result.
// ----------------------------------------------------------------------------
module i2cm_core #(
    parameter int LEN_WIDTH = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 advance,
    input  wire i2cm_pkg::i2cm_req_t  req,
    output i2cm_pkg::i2cm_res_t       res
);

    i2cm_pkg::i2cm_phase_t phase_reg, phase_next, cur_phase;
    logic [3:0]            bit_count_reg, bit_count_next, cur_bit;
    logic [7:0]            shift_reg, shift_next, cur_shift;
    logic [LEN_WIDTH-1:0]  position_reg, position_next, cur_pos;
    logic [LEN_WIDTH-1:0]  total_reg, total_next, cur_total;
    logic                  read_mode_reg, read_mode_next, cur_read;

    logic [LEN_WIDTH-1:0]  len_in;
    logic [LEN_WIDTH-1:0]  pos_inc;
    logic [3:0]            bit_inc;
    logic                  last_byte;
    logic                  scl_o, sda_o, oe_o, rxv_o, done_o, stat_o;
    logic [7:0]            rxb_o;

    assign len_in = req.length[LEN_WIDTH-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= i2cm_pkg::PH_IDLE;
            bit_count_reg <= '0;
            shift_reg     <= '0;
            position_reg  <= '0;
            total_reg     <= '0;
            read_mode_reg <= 1'b0;
        end else if (advance) begin
            phase_reg     <= phase_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            position_reg  <= position_next;
            total_reg     <= total_next;
            read_mode_reg <= read_mode_next;
        end
    end

    always_comb begin
        cur_phase = phase_reg;
        cur_bit   = bit_count_reg;
        cur_shift = shift_reg;
        cur_pos   = position_reg;
        cur_total = total_reg;
        cur_read  = read_mode_reg;
        // start is only honored from idle
        if (phase_reg == i2cm_pkg::PH_IDLE && req.start_req) begin
            cur_total = (len_in == '0) ? LEN_WIDTH'(1) : len_in;
            cur_pos   = '0;
            cur_bit   = '0;
            cur_shift = '0;
            cur_read  = 1'b0;
            cur_phase = i2cm_pkg::PH_ST_A;
        end

        phase_next     = cur_phase;
        bit_count_next = cur_bit;
        shift_next     = cur_shift;
        position_next  = cur_pos;
        total_next     = cur_total;
        read_mode_next = cur_read;

        pos_inc   = cur_pos + LEN_WIDTH'(1);
        bit_inc   = cur_bit + 4'd1;
        last_byte = (pos_inc >= cur_total) || (pos_inc == '0);

        scl_o  = 1'b1;
        sda_o  = 1'b1;
        oe_o   = 1'b1;
        rxb_o  = '0;
        rxv_o  = 1'b0;
        done_o = 1'b0;
        stat_o = 1'b0;

        case (cur_phase)
            i2cm_pkg::PH_IDLE: begin
            end
            i2cm_pkg::PH_ST_A: begin
                phase_next = i2cm_pkg::PH_ST_B;
            end
            i2cm_pkg::PH_ST_B: begin
                sda_o      = 1'b0;
                phase_next = i2cm_pkg::PH_ST_C;
            end
            i2cm_pkg::PH_ST_C: begin
                scl_o          = 1'b0;
                sda_o          = 1'b0;
                bit_count_next = '0;
                phase_next     = i2cm_pkg::PH_TX_SET;
            end
            i2cm_pkg::PH_TX_SET: begin
                if (cur_bit == '0) begin
                    shift_next = req.data_byte;
                    // address byte bit 0 picks the direction
                    if (cur_pos == '0) begin
                        read_mode_next = req.data_byte[0];
                    end
                end
                scl_o      = 1'b0;
                sda_o      = shift_next[7];
                phase_next = i2cm_pkg::PH_TX_HIGH;
            end
            i2cm_pkg::PH_TX_HIGH: begin
                sda_o      = cur_shift[7];
                phase_next = i2cm_pkg::PH_TX_LOW;
            end
            i2cm_pkg::PH_TX_LOW: begin
                scl_o          = 1'b0;
                sda_o          = cur_shift[7];
                shift_next     = {cur_shift[6:0], 1'b0};
                bit_count_next = bit_inc;
                phase_next     = (bit_inc >= i2cm_pkg::BITS_PER_BYTE) ?
                                 i2cm_pkg::PH_TA_REL : i2cm_pkg::PH_TX_SET;
            end
            i2cm_pkg::PH_TA_REL: begin
                scl_o      = 1'b0;
                sda_o      = 1'b0;
                oe_o       = 1'b0;
                phase_next = i2cm_pkg::PH_TA_HIGH;
            end
            i2cm_pkg::PH_TA_HIGH: begin
                sda_o      = 1'b0;
                oe_o       = 1'b0;
                shift_next = {7'd0, req.sda_in};
                phase_next = i2cm_pkg::PH_TA_LOW;
            end
            i2cm_pkg::PH_TA_LOW: begin
                scl_o = 1'b0;
                sda_o = 1'b0;
                oe_o  = 1'b0;
                // nack keeps bit 0 set so stop reports it
                if (cur_shift[0]) begin
                    phase_next = i2cm_pkg::PH_SP_A;
                end else begin
                    position_next  = pos_inc;
                    bit_count_next = '0;
                    if (pos_inc == '0 || pos_inc >= cur_total) begin
                        shift_next = '0;
                        phase_next = i2cm_pkg::PH_SP_A;
                    end else begin
                        phase_next = cur_read ? i2cm_pkg::PH_RX_REL
                                              : i2cm_pkg::PH_TX_SET;
                    end
                end
            end
            i2cm_pkg::PH_RX_REL: begin
                scl_o          = 1'b0;
                sda_o          = 1'b0;
                oe_o           = 1'b0;
                bit_count_next = '0;
                shift_next     = '0;
                phase_next     = i2cm_pkg::PH_RX_HIGH;
            end
            i2cm_pkg::PH_RX_HIGH: begin
                sda_o          = 1'b0;
                oe_o           = 1'b0;
                shift_next     = {cur_shift[6:0], req.sda_in};
                bit_count_next = bit_inc;
                if (bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
                    rxv_o = 1'b1;
                    rxb_o = shift_next;
                end
                phase_next = i2cm_pkg::PH_RX_LOW;
            end
            i2cm_pkg::PH_RX_LOW: begin
                scl_o      = 1'b0;
                sda_o      = 1'b0;
                oe_o       = 1'b0;
                phase_next = (cur_bit >= i2cm_pkg::BITS_PER_BYTE) ?
                             i2cm_pkg::PH_MA_SET : i2cm_pkg::PH_RX_HIGH;
            end
            i2cm_pkg::PH_MA_SET: begin
                scl_o      = 1'b0;
                sda_o      = last_byte;
                phase_next = i2cm_pkg::PH_MA_HIGH;
            end
            i2cm_pkg::PH_MA_HIGH: begin
                sda_o      = last_byte;
                phase_next = i2cm_pkg::PH_MA_LOW;
            end
            i2cm_pkg::PH_MA_LOW: begin
                scl_o         = 1'b0;
                sda_o         = last_byte;
                position_next = pos_inc;
                if (last_byte) begin
                    shift_next = '0;
                    phase_next = i2cm_pkg::PH_SP_A;
                end else begin
                    phase_next = i2cm_pkg::PH_RX_REL;
                end
            end
            i2cm_pkg::PH_SP_A: begin
                scl_o      = 1'b0;
                sda_o      = 1'b0;
                phase_next = i2cm_pkg::PH_SP_B;
            end
            i2cm_pkg::PH_SP_B: begin
                sda_o      = 1'b0;
                phase_next = i2cm_pkg::PH_SP_C;
            end
            i2cm_pkg::PH_SP_C: begin
                done_o     = 1'b1;
                stat_o     = cur_shift[0];
                phase_next = i2cm_pkg::PH_IDLE;
            end
            default: begin
                phase_next = i2cm_pkg::PH_IDLE;
            end
        endcase

        res.scl               = scl_o;
        res.sda_drive         = sda_o;
        res.sda_output_enable = oe_o;
        res.byte_index        = i2cm_pkg::FIELD_LEN_W'(position_next);
        res.rx_byte           = rxb_o;
        res.rx_valid          = rxv_o;
        res.busy_res          = (phase_next != i2cm_pkg::PH_IDLE) || done_o;
        res.done_res          = done_o;
        res.status            = stat_o;
    end

    // a received byte is reported exactly when the eighth bit lands
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res.rx_valid |=> bit_count_reg == i2cm_pkg::BITS_PER_BYTE)
        else $error("rx_valid without a full byte");

    // position never runs past the transfer length
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != i2cm_pkg::PH_IDLE |-> position_reg <= total_reg)
        else $error("position beyond transfer length");

    // a running transfer always has at least the address byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != i2cm_pkg::PH_IDLE |-> total_reg != '0)
        else $error("zero length transfer in progress");

    // while the line is released, the data path holds sda_drive low
    assert property (@(posedge aclk) disable iff (!aresetn)
        !res.sda_output_enable |-> !res.sda_drive)
        else $error("sda drive while released");

endmodule

`default_nettype wire
